/* sv/clcd_pkg.sv */
// shared types, constants and font rom for the character lcd controller
`default_nettype none

package clcd_pkg;

  // item kinds
  typedef enum logic [1:0] {
    OP_CMD   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_PIXEL = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  // configuration register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // command byte, decoded by highest set bit
  localparam int CMD_SET_DDRAM = 7;
  localparam int CMD_IGNORED_HI = 4;  // cgram, function set, shift: bits 6 to 4
  localparam int CMD_DISPLAY   = 3;
  localparam int CMD_ENTRY     = 2;
  localparam int CMD_HOME      = 1;
  localparam int CMD_CLEAR     = 0;
  localparam int ENTRY_INC_BIT = 1;

  // pixel result codes
  localparam logic [1:0] PIX_OFF   = 2'd0;
  localparam logic [1:0] PIX_ON    = 2'd1;
  localparam logic [1:0] PIX_BLANK = 2'd2;

  // character cell geometry
  localparam int GLYPH_W = 5;
  localparam int GLYPH_H = 8;
  localparam int CELL_W  = GLYPH_W + 1;
  localparam int CELL_H  = GLYPH_H + 1;

  // reciprocal constants: x/6 exact for x < 256, y/9 exact for y < 64
  localparam int DIV6_MUL   = 171;
  localparam int DIV6_SHIFT = 10;
  localparam int DIV9_MUL   = 57;
  localparam int DIV9_SHIFT = 9;

  // 5x8 font, column 0 in the top byte, bit 7 is the top pixel row
  localparam logic [39:0] GLYPH_ROM [128] = '{
    40'h0000000000, 40'h7ca28aa27c, 40'h7cd6f6d67c, 40'h387c3e7c38,
    40'h00381c3800, 40'h0c6cfe6c0c, 40'h183a7e3a18, 40'h0018180000,
    40'hffe7e7ffff, 40'h3c24243c00, 40'hc3dbdbc3ff, 40'h0c12526c70,
    40'h60949e9460, 40'h060efc4020, 40'h067e50acfc, 40'h1824242418,
    40'h00fe7c3810, 40'h10387cfe00, 40'h7e7e007e7e, 40'h3c3c3c3c00,
    40'h0a3afa3a0a, 40'hfe7c3810fe, 40'hfe10387cfe, 40'h0101010101,
    40'h0303030303, 40'h0707070707, 40'h0f0f0f0f0f, 40'h1f1f1f1f1f,
    40'h3f3f3f3f3f, 40'h7f7f7f7f7f, 40'h0000000000, 40'h0000000000,
    40'h0000000000, 40'h0060fa6000, 40'he0c000e0c0, 40'h247e247e24,
    40'h2454d64800, 40'hc6c81026c6, 40'h6c926a040a, 40'h00e0c00000,
    40'h007c820000, 40'h00827c0000, 40'h107c387c10, 40'h10107c1010,
    40'h0007060000, 40'h1010101010, 40'h0006060000, 40'h0408102040,
    40'h7c8a92a27c, 40'h0042fe0200, 40'h468a929262, 40'h449292926c,
    40'h182848fe08, 40'hf49292928c, 40'h3c5292920c, 40'h808e90a0c0,
    40'h6c9292926c, 40'h6092929478, 40'h006c6c0000, 40'h0037360000,
    40'h1028448200, 40'h2424242424, 40'h0082442810, 40'h40809a9060,
    40'h7c82baaa78, 40'h7e8888887e, 40'hfe9292926c, 40'h7c82828244,
    40'hfe8282827c, 40'hfe92929282, 40'hfe90909080, 40'h7c8292925e,
    40'hfe101010fe, 40'h0082fe8200, 40'h0c020202fc, 40'hfe10284482,
    40'hfe02020202, 40'hfe402040fe, 40'hfe402010fe, 40'h7c8282827c,
    40'hfe90909060, 40'h7c828a847a, 40'hfe90909866, 40'h649292924c,
    40'h8080fe8080, 40'hfc020202fc, 40'hf8040204f8, 40'hfc023c02fc,
    40'hc6281028c6, 40'he0100e10e0, 40'h8e92a2c200, 40'h00fe828200,
    40'h4020100804, 40'h008282fe00, 40'h2040804020, 40'h0101010101,
    40'h00c0e00000, 40'h042a2a2a1e, 40'hfe2222221c, 40'h1c22222214,
    40'h1c222222fe, 40'h1c2a2a2a10, 40'h107e909000, 40'h182525253e,
    40'hfe20201e00, 40'h0000be0200, 40'h020121be00, 40'hfe08142200,
    40'h0000fe0200, 40'h3e2018201e, 40'h3e20201e00, 40'h1c2222221c,
    40'h3f2222221c, 40'h1c2222223f, 40'h221e222010, 40'h102a2a2a04,
    40'h207c222400, 40'h3c02043e00, 40'h3804020438, 40'h3c060c063c,
    40'h3608083600, 40'h3905063c00, 40'h262a2a3200, 40'h107c828200,
    40'h0000ff0000, 40'h0082827c10, 40'h4080408000, 40'h0101010100
  };

  // one font column of a character; a column past the glyph reads empty
  function automatic logic [7:0] glyph_col(input logic [6:0] code, input logic [2:0] col);
    logic [39:0] g;
    g = GLYPH_ROM[code];
    case (col)
      3'd0:    glyph_col = g[39:32];
      3'd1:    glyph_col = g[31:24];
      3'd2:    glyph_col = g[23:16];
      3'd3:    glyph_col = g[15:8];
      3'd4:    glyph_col = g[7:0];
      default: glyph_col = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

/* sv/char_lcd_controller_core.sv */
// character lcd controller core: display ram, cursor, command decode and pixel rendering
`default_nettype none

// channel   signals                                   direction  accepted when
// --------  ----------------------------------------  ---------  ----------------------
// request   start, operation, value, pixel_x, pixel_y  in         start high, busy low
// result    done, read_data, pixel_code               out        every cycle done is high
// config    cfg_write, cfg_index, cfg_data            in         cfg_write high
//
// a command or data write goes through the exec state before the result strobe; a data
// read or pixel read also goes through the read state, for the registered display ram read
// busy is high from the cycle after acceptance until the result cycle, so a new
// request can be taken in the same cycle that the previous result is shown
// synchronous reset; per-entry valid bits make the ram read as zero, and the clear
// command drops those of the active lines; the receiver cannot stall

module char_lcd_controller_core #(
  parameter int LINE_STRIDE = 41,
  parameter int MAX_ROWS    = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // request channel
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] value,
  input  wire logic [7:0] pixel_x,
  input  wire logic [5:0] pixel_y,
  // result channel
  output logic            done,
  output logic [7:0]      read_data,
  output logic [1:0]      pixel_code,
  // configuration
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [5:0] cfg_data
);

  localparam int RAM_SIZE = LINE_STRIDE * MAX_ROWS;
  localparam int CW       = $clog2(RAM_SIZE);     // cursor / ram address width
  localparam int AW       = CW + 1;               // holds the active size itself
  localparam int RW       = $clog2(MAX_ROWS + 1); // effective row count width

  // configuration registers
  logic [5:0] columns;
  logic [2:0] rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= 6'd16;
      rows    <= 3'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        clcd_pkg::CFG_COLUMNS: columns <= cfg_data;
        clcd_pkg::CFG_ROWS:    rows    <= cfg_data[2:0];
        default:               ;
      endcase
    end
  end

  // effective geometry, out-of-range settings are clamped
  logic [RW-1:0] eff_rows;
  logic [5:0]    eff_cols;
  logic [AW-1:0] active;

  always_comb begin
    if (rows == 3'd0) begin
      eff_rows = RW'(1);
    end else if (32'(rows) > MAX_ROWS) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = RW'(rows);
    end
    if (columns == 6'd0) begin
      eff_cols = 6'd1;
    end else if (32'(columns) > LINE_STRIDE - 1) begin
      eff_cols = 6'(LINE_STRIDE - 1);
    end else begin
      eff_cols = columns;
    end
    active = AW'(32'(eff_rows) * LINE_STRIDE);
  end

  // sequencer
  clcd_pkg::state_t state, state_next;
  clcd_pkg::op_t    op_r;

  logic is_read_op;
  assign is_read_op = (op_r == clcd_pkg::OP_READ) || (op_r == clcd_pkg::OP_PIXEL);

  always_comb begin
    state_next = state;
    case (state)
      clcd_pkg::ST_IDLE: begin
        if (start) state_next = clcd_pkg::ST_EXEC;
      end
      clcd_pkg::ST_EXEC: begin
        state_next = is_read_op ? clcd_pkg::ST_READ : clcd_pkg::ST_IDLE;
      end
      clcd_pkg::ST_READ: begin
        state_next = clcd_pkg::ST_IDLE;
      end
      default: state_next = clcd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= clcd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // control outputs of the sequencer
  logic accept, exec, ram_we, ram_re, finish;

  always_comb begin
    busy   = (state != clcd_pkg::ST_IDLE);
    accept = (state == clcd_pkg::ST_IDLE) && start;
    exec   = (state == clcd_pkg::ST_EXEC);
    ram_we = exec && (op_r == clcd_pkg::OP_WRITE);
    ram_re = exec && is_read_op;
    finish = (exec && !is_read_op) || (state == clcd_pkg::ST_READ);
  end

  // request capture, with the cell coordinates split off by reciprocal multiply
  logic [7:0] value_r, x_r;
  logic [5:0] y_r;
  logic [5:0] qx_r;  // character column under the pixel
  logic [2:0] qy_r;  // character line under the pixel
  logic [15:0] x_prod;
  logic [11:0] y_prod;

  assign x_prod = 16'(32'(pixel_x) * clcd_pkg::DIV6_MUL);
  assign y_prod = 12'(32'(pixel_y) * clcd_pkg::DIV9_MUL);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= clcd_pkg::op_t'(operation);
      value_r <= value;
      x_r     <= pixel_x;
      y_r     <= pixel_y;
      qx_r    <= 6'(x_prod >> clcd_pkg::DIV6_SHIFT);
      qy_r    <= 3'(y_prod >> clcd_pkg::DIV9_SHIFT);
    end
  end

  // cursor and entry mode
  logic [CW-1:0] cursor, cursor_next, cursor_adv;
  logic          auto_inc, auto_inc_next;
  logic          clear_req;

  // advance: step, skip the last slot of a line, wrap at the active size
  logic [AW:0] step1, step2;
  logic        slot_skip;

  always_comb begin
    step1     = (AW + 1)'(cursor) + 1'b1;
    slot_skip = 1'b0;
    for (int k = 1; k <= MAX_ROWS; k++) begin
      if (32'(step1) + 32'd1 == 32'(k * LINE_STRIDE)) slot_skip = 1'b1;
    end
    step2      = slot_skip ? step1 + 1'b1 : step1;
    cursor_adv = (32'(step2) >= 32'(active)) ? '0 : CW'(step2);
  end

  // command decode, highest set bit wins
  logic [CW-1:0] limit;
  logic [6:0]    ddram_addr;

  always_comb begin
    limit         = CW'(active - 1'b1);
    ddram_addr    = value_r[6:0];
    cursor_next   = cursor;
    auto_inc_next = auto_inc;
    clear_req     = 1'b0;
    if (exec && op_r == clcd_pkg::OP_CMD) begin
      if (value_r[clcd_pkg::CMD_SET_DDRAM]) begin
        cursor_next = (32'(ddram_addr) > 32'(limit)) ? limit : CW'(ddram_addr);
      end else if (|value_r[6:clcd_pkg::CMD_IGNORED_HI]) begin
        // cgram address, function set and shift have no effect here
      end else if (value_r[clcd_pkg::CMD_DISPLAY]) begin
        // display control has no effect here
      end else if (value_r[clcd_pkg::CMD_ENTRY]) begin
        auto_inc_next = value_r[clcd_pkg::ENTRY_INC_BIT];
      end else if (value_r[clcd_pkg::CMD_HOME]) begin
        cursor_next = '0;
      end else if (value_r[clcd_pkg::CMD_CLEAR]) begin
        cursor_next = '0;
        clear_req   = 1'b1;
      end
    end else if (ram_we && auto_inc) begin
      cursor_next = cursor_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      auto_inc <= 1'b0;
    end else begin
      cursor   <= cursor_next;
      auto_inc <= auto_inc_next;
    end
  end

  // pixel geometry, worked out while the read address goes out
  logic        outside, gap;
  logic [2:0]  cx;
  logic [3:0]  cy;
  logic [31:0] pix_idx;
  logic [CW-1:0] rd_addr;

  always_comb begin
    outside = (32'(x_r) + 32'd1 >= 32'(eff_cols) * clcd_pkg::CELL_W) ||
              (32'(y_r) + 32'd1 >= 32'(eff_rows) * clcd_pkg::CELL_H);
    cx      = 3'(x_r - 8'(32'(qx_r) * clcd_pkg::CELL_W));
    cy      = 4'(y_r - 6'(32'(qy_r) * clcd_pkg::CELL_H));
    gap     = (32'(cx) == clcd_pkg::GLYPH_W) || (32'(cy) == clcd_pkg::GLYPH_H);
    pix_idx = 32'(qy_r) * LINE_STRIDE + 32'(qx_r);
    if (op_r == clcd_pkg::OP_PIXEL) begin
      // inside the area the cell index always falls within the ram
      rd_addr = outside ? '0 : CW'(pix_idx);
    end else begin
      rd_addr = cursor;
    end
  end

  logic [2:0] cx_r;
  logic [2:0] cy_r;
  logic       blank_r;

  always_ff @(posedge clk) begin
    if (exec) begin
      cx_r    <= cx;
      cy_r    <= cy[2:0];
      blank_r <= outside || gap;
    end
  end

  // display ram: one write port, one registered read port
  logic [7:0]          ram [RAM_SIZE];
  logic [7:0]          ram_q;
  logic [RAM_SIZE-1:0] valid;
  logic                valid_q;

  always_ff @(posedge clk) begin
    if (ram_we) ram[cursor] <= value_r;
    if (ram_re) ram_q <= ram[rd_addr];
  end

  // an entry never written since reset or since a clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ram_re) valid_q <= valid[rd_addr];
      if (clear_req) begin
        for (int i = 0; i < RAM_SIZE; i++) begin
          if (i / LINE_STRIDE < 32'(eff_rows)) valid[i] <= 1'b0;
        end
      end else if (ram_we) begin
        valid[cursor] <= 1'b1;
      end
    end
  end

  // rendering of the fetched character
  logic [7:0] mem_byte;
  logic [6:0] char_code;
  logic [7:0] font_col;
  logic       pix_on;

  always_comb begin
    mem_byte  = valid_q ? ram_q : 8'h00;
    char_code = mem_byte[7] ? 7'd0 : mem_byte[6:0];  // upper half of the code set is blank
    font_col  = clcd_pkg::glyph_col(char_code, cx_r);
    pix_on    = font_col[~cy_r];
  end

  // result register, shown for exactly one cycle
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= finish;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (state == clcd_pkg::ST_READ && op_r == clcd_pkg::OP_READ) begin
        read_data  <= mem_byte;
        pixel_code <= clcd_pkg::PIX_OFF;
      end else if (state == clcd_pkg::ST_READ) begin
        read_data  <= 8'h00;
        if (blank_r)     pixel_code <= clcd_pkg::PIX_BLANK;
        else if (pix_on) pixel_code <= clcd_pkg::PIX_ON;
        else             pixel_code <= clcd_pkg::PIX_OFF;
      end else begin
        read_data  <= 8'h00;
        pixel_code <= clcd_pkg::PIX_OFF;
      end
    end
  end

endmodule

`default_nettype wire

/* test/char_lcd_checker.sv */
// result checker for the character lcd controller: shadow display state and result compare
`timescale 1ns / 100ps

module char_lcd_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] value,
  input  wire logic [7:0] pixel_x,
  input  wire logic [5:0] pixel_y,
  input  wire logic       done,
  input  wire logic [7:0] read_data,
  input  wire logic [1:0] pixel_code,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [5:0] cfg_data,
  output int              failures,
  output int              outstanding
);

  localparam int LINE_STRIDE = 41;
  localparam int MAX_ROWS    = 4;
  localparam int RAM_DEPTH   = LINE_STRIDE * MAX_ROWS;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] pixel_code;
  } lcd_result_t;

  // 5x8 font, first column in the top byte, bit 7 is the top pixel row
  localparam logic [39:0] glyph_cols [128] = '{
    40'h0000000000, 40'h7ca28aa27c, 40'h7cd6f6d67c, 40'h387c3e7c38,
    40'h00381c3800, 40'h0c6cfe6c0c, 40'h183a7e3a18, 40'h0018180000,
    40'hffe7e7ffff, 40'h3c24243c00, 40'hc3dbdbc3ff, 40'h0c12526c70,
    40'h60949e9460, 40'h060efc4020, 40'h067e50acfc, 40'h1824242418,
    40'h00fe7c3810, 40'h10387cfe00, 40'h7e7e007e7e, 40'h3c3c3c3c00,
    40'h0a3afa3a0a, 40'hfe7c3810fe, 40'hfe10387cfe, 40'h0101010101,
    40'h0303030303, 40'h0707070707, 40'h0f0f0f0f0f, 40'h1f1f1f1f1f,
    40'h3f3f3f3f3f, 40'h7f7f7f7f7f, 40'h0000000000, 40'h0000000000,
    40'h0000000000, 40'h0060fa6000, 40'he0c000e0c0, 40'h247e247e24,
    40'h2454d64800, 40'hc6c81026c6, 40'h6c926a040a, 40'h00e0c00000,
    40'h007c820000, 40'h00827c0000, 40'h107c387c10, 40'h10107c1010,
    40'h0007060000, 40'h1010101010, 40'h0006060000, 40'h0408102040,
    40'h7c8a92a27c, 40'h0042fe0200, 40'h468a929262, 40'h449292926c,
    40'h182848fe08, 40'hf49292928c, 40'h3c5292920c, 40'h808e90a0c0,
    40'h6c9292926c, 40'h6092929478, 40'h006c6c0000, 40'h0037360000,
    40'h1028448200, 40'h2424242424, 40'h0082442810, 40'h40809a9060,
    40'h7c82baaa78, 40'h7e8888887e, 40'hfe9292926c, 40'h7c82828244,
    40'hfe8282827c, 40'hfe92929282, 40'hfe90909080, 40'h7c8292925e,
    40'hfe101010fe, 40'h0082fe8200, 40'h0c020202fc, 40'hfe10284482,
    40'hfe02020202, 40'hfe402040fe, 40'hfe402010fe, 40'h7c8282827c,
    40'hfe90909060, 40'h7c828a847a, 40'hfe90909866, 40'h649292924c,
    40'h8080fe8080, 40'hfc020202fc, 40'hf8040204f8, 40'hfc023c02fc,
    40'hc6281028c6, 40'he0100e10e0, 40'h8e92a2c200, 40'h00fe828200,
    40'h4020100804, 40'h008282fe00, 40'h2040804020, 40'h0101010101,
    40'h00c0e00000, 40'h042a2a2a1e, 40'hfe2222221c, 40'h1c22222214,
    40'h1c222222fe, 40'h1c2a2a2a10, 40'h107e909000, 40'h182525253e,
    40'hfe20201e00, 40'h0000be0200, 40'h020121be00, 40'hfe08142200,
    40'h0000fe0200, 40'h3e2018201e, 40'h3e20201e00, 40'h1c2222221c,
    40'h3f2222221c, 40'h1c2222223f, 40'h221e222010, 40'h102a2a2a04,
    40'h207c222400, 40'h3c02043e00, 40'h3804020438, 40'h3c060c063c,
    40'h3608083600, 40'h3905063c00, 40'h262a2a3200, 40'h107c828200,
    40'h0000ff0000, 40'h0082827c10, 40'h4080408000, 40'h0101010100
  };

  logic [7:0]  shadow_ram [RAM_DEPTH];
  int          cursor;
  logic        auto_inc;
  logic [5:0]  columns_reg;
  logic [2:0]  rows_reg;
  lcd_result_t awaited_results [$];

  function automatic int lines_in_use();
    if (rows_reg == 3'd0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int chars_per_line();
    if (columns_reg == 6'd0) return 1;
    if (columns_reg > LINE_STRIDE - 1) return LINE_STRIDE - 1;
    return columns_reg;
  endfunction

  function automatic logic [1:0] pixel_value(input int x, input int y);
    int          cx;
    int          cy;
    int          idx;
    logic [7:0]  code;
    logic [39:0] glyph;
    logic [7:0]  col_bits;
    if (x >= chars_per_line() * clcd_pkg::CELL_W - 1 ||
        y >= lines_in_use() * clcd_pkg::CELL_H - 1)
      return clcd_pkg::PIX_BLANK;
    cx = x % clcd_pkg::CELL_W;
    cy = y % clcd_pkg::CELL_H;
    if (cx == clcd_pkg::GLYPH_W || cy == clcd_pkg::GLYPH_H) return clcd_pkg::PIX_BLANK;
    idx = (y / clcd_pkg::CELL_H) * LINE_STRIDE + x / clcd_pkg::CELL_W;
    if (idx >= RAM_DEPTH) return clcd_pkg::PIX_BLANK;
    code = shadow_ram[idx];
    // codes with the top bit set show as blank
    if (code[7]) code = 8'h00;
    glyph = glyph_cols[code[6:0]];
    col_bits = glyph[39 - 8 * cx -: 8];
    return col_bits[7 - cy] ? clcd_pkg::PIX_ON : clcd_pkg::PIX_OFF;
  endfunction

  task automatic apply_request(input logic [1:0] op, input logic [7:0] val,
                               input logic [7:0] x, input logic [5:0] y,
                               output lcd_result_t res);
    int active;
    active = LINE_STRIDE * lines_in_use();
    res.read_data = 8'h00;
    res.pixel_code = clcd_pkg::PIX_OFF;
    case (op)
      clcd_pkg::OP_CMD: begin
        if (val[clcd_pkg::CMD_SET_DDRAM]) begin
          cursor = (val[6:0] > active - 1) ? active - 1 : val[6:0];
        end else if (val[6:clcd_pkg::CMD_IGNORED_HI] == 3'd0 &&
                     !val[clcd_pkg::CMD_DISPLAY]) begin
          if (val[clcd_pkg::CMD_ENTRY]) begin
            auto_inc = val[clcd_pkg::ENTRY_INC_BIT];
          end else if (val[clcd_pkg::CMD_HOME]) begin
            cursor = 0;
          end else if (val[clcd_pkg::CMD_CLEAR]) begin
            for (int i = 0; i < active; i++) shadow_ram[i] = 8'h00;
            cursor = 0;
          end
        end
      end
      clcd_pkg::OP_WRITE: begin
        if (cursor < RAM_DEPTH) shadow_ram[cursor] = val;
        if (auto_inc) begin
          cursor = cursor + 1;
          if ((cursor + 1) % LINE_STRIDE == 0) cursor = cursor + 1;
          if (cursor >= active) cursor = 0;
        end
      end
      clcd_pkg::OP_READ: begin
        if (cursor < RAM_DEPTH) res.read_data = shadow_ram[cursor];
      end
      default: begin
        res.pixel_code = pixel_value(x, y);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    lcd_result_t want;
    if (rst) begin
      for (int i = 0; i < RAM_DEPTH; i++) shadow_ram[i] = 8'h00;
      cursor = 0;
      auto_inc = 1'b0;
      columns_reg = 6'd16;
      rows_reg = 3'd2;
      failures = 0;
      awaited_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (awaited_results.size() == 0) begin
          failures = failures + 1;
          $display("%0t: result with none expected, read_data %02h pixel_code %0d",
                   $time, read_data, pixel_code);
        end else begin
          want = awaited_results.pop_front();
          if (read_data !== want.read_data) begin
            failures = failures + 1;
            $display("%0t: read_data expected %02h actual %02h",
                     $time, want.read_data, read_data);
          end
          if (pixel_code !== want.pixel_code) begin
            failures = failures + 1;
            $display("%0t: pixel_code expected %0d actual %0d",
                     $time, want.pixel_code, pixel_code);
          end
        end
      end
      if (cfg_write === 1'b1) begin
        if (cfg_index == clcd_pkg::CFG_COLUMNS) columns_reg = cfg_data;
        else rows_reg = cfg_data[2:0];
      end
      if (start === 1'b1 && busy === 1'b0) begin
        apply_request(operation, value, pixel_x, pixel_y, want);
        awaited_results.push_back(want);
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

/* test/char_lcd_controller_core_tb.sv */
// testbench top for the character lcd controller: stimulus, reset, timeout and verdict
`timescale 1ns / 100ps

module char_lcd_controller_core_tb;

  // far beyond the slowest correct run
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] operation = clcd_pkg::OP_CMD;
  logic [7:0] value = 8'h00;
  logic [7:0] pixel_x = 8'h00;
  logic [5:0] pixel_y = 6'd0;
  logic       done;
  logic [7:0] read_data;
  logic [1:0] pixel_code;
  logic       cfg_write = 1'b0;
  logic       cfg_index = clcd_pkg::CFG_COLUMNS;
  logic [5:0] cfg_data = 6'd0;

  int          failures;
  int          outstanding;
  int unsigned cycle_count = 0;

  // sender burst state and the pixel span the current geometry covers
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int span_x = 96;
  int span_y = 18;

  // geometry for each random phase; the last one is drawn at random
  int phase_cols [8] = '{40, 0, 63, 1, 41, 24, 40, 0};
  int phase_rows [8] = '{1, 0, 7, 4, 5, 3, 4, 0};

  char_lcd_controller_core uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .value      (value),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .done       (done),
    .read_data  (read_data),
    .pixel_code (pixel_code),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  char_lcd_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value       (value),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .done        (done),
    .read_data   (read_data),
    .pixel_code  (pixel_code),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("char_lcd_controller_core_tb NOT OK");
      $finish;
    end
  end

  // one request: hold start until the block takes it, then maybe pause
  task automatic issue(input logic [1:0] op, input logic [7:0] val,
                       input logic [7:0] x, input logic [5:0] y);
    start <= 1'b1;
    operation <= op;
    value <= val;
    pixel_x <= x;
    pixel_y <= y;
    do @(posedge clk); while (busy !== 1'b0);
    if (gaps_on) begin
      if (burst_left == 0) begin
        // idle gap with junk on the request fields, which the block must ignore
        start <= 1'b0;
        operation <= 2'($urandom_range(0, 3));
        value <= 8'($urandom_range(0, 255));
        pixel_x <= 8'($urandom_range(0, 255));
        pixel_y <= 6'($urandom_range(0, 63));
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left = burst_left - 1;
      end
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // both registers are written back to back while the block is idle
  task automatic set_geometry(input int cols, input int nrows);
    logic [2:0] row_bits;
    logic [2:0] spare_bits;
    int         ec;
    int         er;
    row_bits = 3'(nrows);
    spare_bits = 3'($urandom_range(0, 7));
    cfg_write <= 1'b1;
    cfg_index <= clcd_pkg::CFG_COLUMNS;
    cfg_data <= 6'(cols);
    @(posedge clk);
    // the upper data bits are don't-care for the row count
    cfg_index <= clcd_pkg::CFG_ROWS;
    cfg_data <= {spare_bits, row_bits};
    @(posedge clk);
    cfg_write <= 1'b0;
    ec = (cols % 64 == 0) ? 1 : (cols % 64 > 40) ? 40 : cols % 64;
    er = (row_bits == 3'd0) ? 1 : (row_bits > 3'd4) ? 4 : row_bits;
    span_x = ec * clcd_pkg::CELL_W;
    span_y = er * clcd_pkg::CELL_H;
  endtask

  // random request, weighted so the ram fills up and pixel reads land on text
  task automatic random_request();
    int         pick;
    int         kind;
    logic [7:0] v;
    logic [7:0] x;
    logic [5:0] y;
    pick = $urandom_range(0, 99);
    v = 8'($urandom_range(0, 255));
    x = 8'($urandom_range(0, 255));
    y = 6'($urandom_range(0, 63));
    if (pick < 35) begin
      // mostly printable text, some codes above the font
      if ($urandom_range(0, 3) != 0) v = 8'($urandom_range(32, 126));
      issue(clcd_pkg::OP_WRITE, v, x, y);
    end else if (pick < 50) begin
      issue(clcd_pkg::OP_READ, v, x, y);
    end else if (pick < 80) begin
      // mostly inside the panel plus its edge, now and then anywhere
      if ($urandom_range(0, 4) != 0) begin
        x = 8'($urandom_range(0, span_x));
        y = 6'($urandom_range(0, span_y));
      end
      issue(clcd_pkg::OP_PIXEL, v, x, y);
    end else begin
      kind = $urandom_range(0, 19);
      if (kind < 8) v = 8'h80 | 8'($urandom_range(0, 127));       // set address
      else if (kind < 12) v = 8'h04 | 8'($urandom_range(0, 3));   // entry mode
      else if (kind < 14) v = 8'h02 | 8'($urandom_range(0, 1));   // home
      else if (kind == 14) v = 8'h01;                             // clear
      else if (kind < 19) v = 8'($urandom_range(8, 127));         // ignored group
      else v = 8'h00;
      issue(clcd_pkg::OP_CMD, v, x, y);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: sixteen columns on two lines, empty ram
    issue(clcd_pkg::OP_READ, 8'h00, 8'd0, 6'd0);
    issue(clcd_pkg::OP_PIXEL, 8'h00, 8'd0, 6'd0);
    issue(clcd_pkg::OP_PIXEL, 8'h00, 8'd95, 6'd17);   // first column past the panel
    drain();

    // widest panel, all four lines
    set_geometry(40, 4);
    issue(clcd_pkg::OP_CMD, 8'h06, 8'd0, 6'd0);       // entry mode, increment on
    issue(clcd_pkg::OP_CMD, 8'ha6, 8'd0, 6'd0);       // address 38, near the end of line 0
    issue(clcd_pkg::OP_WRITE, 8'h41, 8'd0, 6'd0);
    issue(clcd_pkg::OP_WRITE, 8'hff, 8'd0, 6'd0);     // skips the spare slot onto line 1
    issue(clcd_pkg::OP_READ, 8'h00, 8'd0, 6'd0);
    issue(clcd_pkg::OP_PIXEL, 8'h00, 8'd228, 6'd1);   // inside the letter
    issue(clcd_pkg::OP_PIXEL, 8'h00, 8'd233, 6'd0);   // gap column
    issue(clcd_pkg::OP_PIXEL, 8'h00, 8'd229, 6'd8);   // gap row
    issue(clcd_pkg::OP_PIXEL, 8'h00, 8'd236, 6'd3);   // code above the font shows blank
    issue(clcd_pkg::OP_PIXEL, 8'h00, 8'd239, 6'd0);   // right edge of the panel
    issue(clcd_pkg::OP_PIXEL, 8'h00, 8'd255, 6'd63);
    issue(clcd_pkg::OP_CMD, 8'hff, 8'd0, 6'd0);       // address 127 lies inside the active size, so no clamp
    issue(clcd_pkg::OP_WRITE, 8'h7f, 8'd0, 6'd0);     // cursor steps on to 128
    issue(clcd_pkg::OP_READ, 8'h00, 8'd0, 6'd0);
    issue(clcd_pkg::OP_CMD, 8'h40, 8'd0, 6'd0);
    issue(clcd_pkg::OP_CMD, 8'h20, 8'd0, 6'd0);
    issue(clcd_pkg::OP_CMD, 8'h10, 8'd0, 6'd0);
    issue(clcd_pkg::OP_CMD, 8'h08, 8'd0, 6'd0);
    issue(clcd_pkg::OP_CMD, 8'h00, 8'd0, 6'd0);
    issue(clcd_pkg::OP_CMD, 8'h02, 8'd0, 6'd0);       // home
    issue(clcd_pkg::OP_CMD, 8'h04, 8'd0, 6'd0);       // entry mode, increment off
    issue(clcd_pkg::OP_WRITE, 8'h55, 8'd0, 6'd0);
    issue(clcd_pkg::OP_READ, 8'h00, 8'd0, 6'd0);      // cursor stayed put
    issue(clcd_pkg::OP_CMD, 8'h01, 8'd0, 6'd0);       // clear
    issue(clcd_pkg::OP_READ, 8'h00, 8'd0, 6'd0);
    issue(clcd_pkg::OP_PIXEL, 8'h00, 8'd228, 6'd1);

    phase_cols[7] = $urandom_range(0, 63);
    phase_rows[7] = $urandom_range(0, 7);
    for (int p = 0; p < 8; p++) begin
      // park the cursor; the top slot on entry to the single-line phase strands it
      if (p == 0) issue(clcd_pkg::OP_CMD, 8'hff, 8'd0, 6'd0);
      else issue(clcd_pkg::OP_CMD, 8'h80 | 8'($urandom_range(0, 127)), 8'd0, 6'd0);
      drain();
      set_geometry(phase_cols[p], phase_rows[p]);
      // every third phase runs back to back with no gaps
      gaps_on = (p % 3 != 2);
      repeat (80) random_request();
    end

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("char_lcd_controller_core_tb OK");
    end else begin
      $display("char_lcd_controller_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/clcd_pkg.sv
sv/char_lcd_controller_core.sv
test/char_lcd_checker.sv
test/char_lcd_controller_core_tb.sv
